// ===== sv/ph_sample_filter_and_calibration_assert.svh =====
// Assertion macros shared by the pH sample filter and calibration block.
`ifndef PH_SAMPLE_FILTER_AND_CALIBRATION_ASSERT_SVH
`define PH_SAMPLE_FILTER_AND_CALIBRATION_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PSFC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ph filter: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PSFC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ph filter: next-cycle check failed");

`endif

// ===== sv/ph_sfc_pkg.sv =====
// Constants, register indexes and curve codes of the pH sample filter and calibration block.
package ph_sfc_pkg;

   // Block configuration defaults.
   localparam int SAMPLES_PER_BLOCK_DEF = 10;
   localparam bit DIFFERENTIAL_INPUT    = 1'b1;

   // Field widths.
   localparam int ADC_W      = 16;
   localparam int VOLT_W     = 20;
   localparam int PROBE_W    = 21;
   localparam int PH_W       = 16;
   localparam int SLOPE_W    = 24;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Serial multiplier: magnitude of the voltage difference times three times the slope magnitude.
   localparam int MAG_W    = VOLT_W + 1;
   localparam int MCAND_W  = SLOPE_W + 2;
   localparam int PROD_W   = MAG_W + MCAND_W;

   // The curve divides by 4096000 = 2^15 * 125, rounding to nearest.
   localparam int CURVE_SHIFT   = 15;
   localparam int CURVE_ROUND   = 2048000;
   localparam int CURVE_DIVISOR = 125;
   localparam int CURVE_Q_W     = PROD_W - CURVE_SHIFT;

   // Shared serial divider divisor width (covers 125 and the block length).
   localparam int DSOR_W = 7;

   // Adaptive smoothing: 3/10 on a large step, 2/25 otherwise.
   localparam int SMOOTH_FAST_DIV   = 10;
   localparam int SMOOTH_FAST_ROUND = 5;
   localparam int SMOOTH_SLOW_DIV   = 25;
   localparam int SMOOTH_SLOW_ROUND = 12;

   // pH values in Q4.12.
   localparam logic [PH_W-1:0] PH_SEVEN      = 16'd28672;
   localparam logic [PH_W-1:0] PH_MAX        = 16'd57344;
   localparam logic [PH_W-1:0] PH_STEP_LIMIT = 16'd2048;

   localparam logic signed [ADC_W-1:0]   ADC_POS_MAX = 16'sd32767;
   localparam logic signed [SLOPE_W-1:0] SLOPE_RESET = 24'sd278004;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_CURVE_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CURVE_VALID     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NEUTRAL_VOLTAGE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SINGLE_SLOPE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ACID_SLOPE      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_SLOPE      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_THEORY_OFFSET   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_THEORY_SLOPE    = 3'd7;

   // Curve selection codes.
   localparam logic [MODE_W-1:0] MODE_THEORY      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TWO_POINT   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_THREE_POINT = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FIXED       = 2'd3;

endpackage

// ===== sv/ph_sample_filter_and_calibration.sv =====
// Top level of the pH sample filter and calibration block.
//
// Each request carries one converter code. Codes that do not close a block are taken one per
// cycle. The request that closes a block of SAMPLES_PER_BLOCK codes holds req_stall high while
// one shared bit-serial divider (one quotient bit per cycle) and a bit-serial shift-add
// multiplier work the result: three divider passes (block average, curve, smoothing), the
// multiply and six further steps (median, multiplier load, curve load, pH, smoothing load,
// output); the output step also waits for the previous result to be taken. Results leave
// through an output register; one result per block.
module ph_sample_filter_and_calibration #(
   parameter int SAMPLES_PER_BLOCK = ph_sfc_pkg::SAMPLES_PER_BLOCK_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic signed [ph_sfc_pkg::ADC_W-1:0]        req_adc_code,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [ph_sfc_pkg::VOLT_W-1:0]       rsp_filtered_voltage,
   output logic signed [ph_sfc_pkg::PROBE_W-1:0]      rsp_probe_voltage,
   output logic        [ph_sfc_pkg::PH_W-1:0]         rsp_ph_instant,
   output logic        [ph_sfc_pkg::PH_W-1:0]         rsp_ph_smoothed,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic        [ph_sfc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic        [ph_sfc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ph_sfc_pkg::*;

   localparam int CNT_W  = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
   localparam int SUM_W  = ADC_W + $clog2(SAMPLES_PER_BLOCK);
   localparam int DIV_W  = SUM_W + 5;
   localparam int DQ_W   = (DIV_W > CURVE_Q_W) ? DIV_W : CURVE_Q_W;
   localparam int STEP_W = $clog2(DQ_W);
   localparam int HALF_N = SAMPLES_PER_BLOCK / 2;

   // Sequencer states.
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DIVV = 4'd1;
   localparam logic [3:0] S_MED  = 4'd2;
   localparam logic [3:0] S_PREP = 4'd3;
   localparam logic [3:0] S_MUL  = 4'd4;
   localparam logic [3:0] S_CURV = 4'd5;
   localparam logic [3:0] S_DIVP = 4'd6;
   localparam logic [3:0] S_PH   = 4'd7;
   localparam logic [3:0] S_SMTH = 4'd8;
   localparam logic [3:0] S_DIVS = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;

   // Configuration registers.
   logic [MODE_W-1:0]         mode_ff, mode_in;
   logic                      cvalid_ff, cvalid_in;
   logic signed [VOLT_W-1:0]  neutral_ff, neutral_in;
   logic signed [SLOPE_W-1:0] single_ff, single_in;
   logic signed [SLOPE_W-1:0] acid_ff, acid_in;
   logic signed [SLOPE_W-1:0] base_ff, base_in;
   logic signed [VOLT_W-1:0]  toff_ff, toff_in;
   logic signed [SLOPE_W-1:0] tslope_ff, tslope_in;

   // Sequencer, accumulator and filter state.
   logic [3:0]                state_ff, state_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [VOLT_W-1:0]  hist_ff [3];
   logic signed [VOLT_W-1:0]  hist_in [3];
   logic [1:0]                hptr_ff, hptr_in;
   logic [1:0]                hfill_ff, hfill_in;
   logic                      first_ff, first_in;
   logic [PH_W-1:0]           smooth_ff, smooth_in;

   // Datapath working registers.
   logic [DQ_W-1:0]           dq_ff, dq_in;
   logic [DSOR_W-1:0]         rem_ff, rem_in;
   logic [DSOR_W-1:0]         dsor_ff, dsor_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      neg_ff, neg_in;
   logic signed [VOLT_W-1:0]  filt_ff, filt_in;
   logic [MCAND_W-1:0]        mcand_ff, mcand_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [PH_W-1:0]           ph_ff, ph_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VOLT_W-1:0]  rsp_filt_ff, rsp_filt_in;
   logic signed [PROBE_W-1:0] rsp_probe_ff, rsp_probe_in;
   logic [PH_W-1:0]           rsp_phi_ff, rsp_phi_in;
   logic [PH_W-1:0]           rsp_phs_ff, rsp_phs_in;

   // Combinational helpers.
   logic signed [ADC_W:0]     code_neg;
   logic signed [ADC_W-1:0]   code_diff;
   logic signed [ADC_W-1:0]   code_use;
   logic signed [SUM_W-1:0]   sum_add;
   logic [SUM_W-1:0]          sum_mag;
   logic                      req_take;
   logic                      block_end;
   logic [DSOR_W:0]           div_sh;
   logic                      div_ge;
   logic [DSOR_W-1:0]         div_rem;
   logic [VOLT_W-1:0]         vq;
   logic signed [VOLT_W-1:0]  vblk;
   logic                      use_cal;
   logic signed [VOLT_W-1:0]  v0;
   logic signed [SLOPE_W-1:0] slope_sel;
   logic signed [MAG_W-1:0]   vdiff;
   logic [MAG_W-1:0]          vdiff_mag;
   logic [SLOPE_W-1:0]        slope_mag;
   logic [MCAND_W:0]          mul_sum;
   logic [PROD_W-1:0]         curve_num;
   logic signed [PH_W:0]      dsm;
   logic [PH_W-1:0]           dmag;
   logic                      dbig;
   logic [PH_W+1:0]           sm_load;
   logic [PH_W-1:0]           sq;
   logic [MAG_W-1:0]          fmag;
   logic [MAG_W+1:0]          p3;
   logic [MAG_W+1:0]          p3r;
   logic [PROBE_W-1:0]        phalf;
   logic                      out_free;

   // Median of three signed values.
   function automatic logic signed [VOLT_W-1:0] med3(
      input logic signed [VOLT_W-1:0] a,
      input logic signed [VOLT_W-1:0] b,
      input logic signed [VOLT_W-1:0] c
   );
      logic signed [VOLT_W-1:0] lo;
      logic signed [VOLT_W-1:0] hi;
      logic signed [VOLT_W-1:0] mid;
      lo  = (a < b) ? a : b;
      hi  = (a < b) ? b : a;
      mid = (hi < c) ? hi : c;
      return (lo > mid) ? lo : mid;
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_filtered_voltage = rsp_filt_ff;
   assign rsp_probe_voltage    = rsp_probe_ff;
   assign rsp_ph_instant       = rsp_phi_ff;
   assign rsp_ph_smoothed      = rsp_phs_ff;

   // Input conditioning: differential inputs are negated and clamped to the positive range.
   assign code_neg  = -{req_adc_code[ADC_W-1], req_adc_code};
   assign code_diff = code_neg[ADC_W] ? '0 :
                      (code_neg[ADC_W-1] ? ADC_POS_MAX : code_neg[ADC_W-1:0]);
   assign code_use  = DIFFERENTIAL_INPUT ? code_diff : req_adc_code;
   assign sum_add   = sum_ff + SUM_W'(code_use);
   assign sum_mag   = sum_add[SUM_W-1] ? SUM_W'(-sum_add) : SUM_W'(sum_add);
   assign req_take  = req_valid && !req_stall;
   assign block_end = (count_ff == CNT_W'(SAMPLES_PER_BLOCK - 1));

   // One restoring division step: one quotient bit per cycle.
   assign div_sh  = {rem_ff, dq_ff[DQ_W-1]};
   assign div_ge  = (div_sh >= {1'b0, dsor_ff});
   assign div_rem = div_ge ? DSOR_W'(div_sh - {1'b0, dsor_ff}) : div_sh[DSOR_W-1:0];

   // Block voltage from the unsigned quotient and the saved sign.
   assign vq   = dq_ff[VOLT_W-1:0];
   assign vblk = neg_ff ? -$signed(vq) : $signed(vq);

   // Curve selection; missing calibration falls back to the theoretical curve.
   assign use_cal = cvalid_ff && (mode_ff == MODE_TWO_POINT || mode_ff == MODE_THREE_POINT);
   assign v0      = use_cal ? neutral_ff : toff_ff;
   always_comb begin
      slope_sel = tslope_ff;
      if (use_cal) begin
         if (mode_ff == MODE_TWO_POINT) begin
            slope_sel = single_ff;
         end else begin
            slope_sel = (filt_ff >= neutral_ff) ? acid_ff : base_ff;
         end
      end
   end
   assign vdiff     = {v0[VOLT_W-1], v0} - {filt_ff[VOLT_W-1], filt_ff};
   assign vdiff_mag = vdiff[MAG_W-1] ? MAG_W'(-vdiff) : MAG_W'(vdiff);
   assign slope_mag = slope_sel[SLOPE_W-1] ? SLOPE_W'(-slope_sel) : SLOPE_W'(slope_sel);

   // One shift-add multiply step on the low bit of the multiplier.
   assign mul_sum   = {1'b0, prod_ff[PROD_W-1:MAG_W]} +
                      (prod_ff[0] ? {1'b0, mcand_ff} : '0);
   assign curve_num = prod_ff + PROD_W'(CURVE_ROUND);

   // Smoothing step size and its rounded division operand.
   assign dsm     = $signed({1'b0, ph_ff}) - $signed({1'b0, smooth_ff});
   assign dmag    = dsm[PH_W] ? PH_W'(-dsm) : PH_W'(dsm);
   assign dbig    = (dmag > PH_STEP_LIMIT);
   assign sm_load = dbig ? ({2'b0, dmag} + {1'b0, dmag, 1'b0} + (PH_W+2)'(SMOOTH_FAST_ROUND))
                         : ({1'b0, dmag, 1'b0} + (PH_W+2)'(SMOOTH_SLOW_ROUND));
   assign sq      = dq_ff[PH_W-1:0];

   // Probe voltage: filtered voltage times 3/2, rounded away from zero on ties.
   assign fmag  = filt_ff[VOLT_W-1] ? MAG_W'(-{filt_ff[VOLT_W-1], filt_ff})
                                    : MAG_W'({1'b0, filt_ff});
   assign p3    = {2'b0, fmag} + {1'b0, fmag, 1'b0};
   assign p3r   = p3 + (MAG_W+2)'(1);
   assign phalf = PROBE_W'(p3r[MAG_W+1:1]);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next-state logic of the sequencer and datapath.
   always_comb begin
      mode_in    = mode_ff;
      cvalid_in  = cvalid_ff;
      neutral_in = neutral_ff;
      single_in  = single_ff;
      acid_in    = acid_ff;
      base_in    = base_ff;
      toff_in    = toff_ff;
      tslope_in  = tslope_ff;
      state_in   = state_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      for (int i = 0; i < 3; i++) begin
         hist_in[i] = hist_ff[i];
      end
      hptr_in    = hptr_ff;
      hfill_in   = hfill_ff;
      first_in   = first_ff;
      smooth_in  = smooth_ff;
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      dsor_in    = dsor_ff;
      step_in    = step_ff;
      neg_in     = neg_ff;
      filt_in    = filt_ff;
      mcand_in   = mcand_ff;
      prod_in    = prod_ff;
      ph_in      = ph_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_filt_in  = rsp_filt_ff;
      rsp_probe_in = rsp_probe_ff;
      rsp_phi_in   = rsp_phi_ff;
      rsp_phs_in   = rsp_phs_ff;

      // Configuration writes; the port is always ready.
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_CURVE_MODE:      mode_in    = csr_wdata[MODE_W-1:0];
            REG_CURVE_VALID:     cvalid_in  = csr_wdata[0];
            REG_NEUTRAL_VOLTAGE: neutral_in = $signed(csr_wdata[VOLT_W-1:0]);
            REG_SINGLE_SLOPE:    single_in  = $signed(csr_wdata[SLOPE_W-1:0]);
            REG_ACID_SLOPE:      acid_in    = $signed(csr_wdata[SLOPE_W-1:0]);
            REG_BASE_SLOPE:      base_in    = $signed(csr_wdata[SLOPE_W-1:0]);
            REG_THEORY_OFFSET:   toff_in    = $signed(csr_wdata[VOLT_W-1:0]);
            REG_THEORY_SLOPE:    tslope_in  = $signed(csr_wdata[SLOPE_W-1:0]);
            default: ;
         endcase
      end

      case (state_ff)
         // Accumulate codes; the last code of a block starts the average division.
         S_IDLE: begin
            if (req_take) begin
               if (block_end) begin
                  sum_in   = '0;
                  count_in = '0;
                  neg_in   = sum_add[SUM_W-1];
                  dq_in    = DQ_W'({sum_mag, 4'b0}) + DQ_W'(HALF_N);
                  rem_in   = '0;
                  dsor_in  = DSOR_W'(SAMPLES_PER_BLOCK);
                  step_in  = STEP_W'(DQ_W - 1);
                  state_in = S_DIVV;
               end else begin
                  sum_in   = sum_add;
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end

         // Divider passes share one step; each leads to its own follow-up state.
         S_DIVV, S_DIVP, S_DIVS: begin
            dq_in  = {dq_ff[DQ_W-2:0], div_ge};
            rem_in = div_rem;
            if (step_ff == '0) begin
               case (state_ff)
                  S_DIVV:  state_in = S_MED;
                  S_DIVP:  state_in = S_PH;
                  default: state_in = S_OUT;
               endcase
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end

         // Store the block voltage and take the median once three values are held.
         S_MED: begin
            for (int i = 0; i < 3; i++) begin
               if (hptr_ff == 2'(i)) begin
                  hist_in[i] = vblk;
               end
            end
            hptr_in  = (hptr_ff == 2'd2) ? 2'd0 : hptr_ff + 2'd1;
            hfill_in = (hfill_ff == 2'd3) ? 2'd3 : hfill_ff + 2'd1;
            filt_in  = (hfill_in == 2'd3) ? med3(hist_in[0], hist_in[1], hist_in[2]) : vblk;
            state_in = S_PREP;
         end

         // Load the multiplier with |V0 - V| and three times |slope|.
         S_PREP: begin
            neg_in   = vdiff[MAG_W-1] ^ slope_sel[SLOPE_W-1];
            mcand_in = {2'b0, slope_mag} + {1'b0, slope_mag, 1'b0};
            prod_in  = {{MCAND_W{1'b0}}, vdiff_mag};
            step_in  = STEP_W'(MAG_W - 1);
            state_in = S_MUL;
         end

         S_MUL: begin
            prod_in = {mul_sum, prod_ff[MAG_W-1:1]};
            if (step_ff == '0) begin
               state_in = S_CURV;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end

         // Round, drop the power-of-two part and divide the rest by 125.
         S_CURV: begin
            dq_in    = DQ_W'(curve_num[PROD_W-1:CURVE_SHIFT]);
            rem_in   = '0;
            dsor_in  = DSOR_W'(CURVE_DIVISOR);
            step_in  = STEP_W'(DQ_W - 1);
            state_in = S_DIVP;
         end

         // Offset from pH 7 and clamp to the 0..14 range; fixed mode always gives pH 7.
         S_PH: begin
            if (mode_ff == MODE_FIXED) begin
               ph_in = PH_SEVEN;
            end else if (dq_ff >= DQ_W'(PH_SEVEN)) begin
               ph_in = neg_ff ? '0 : PH_MAX;
            end else begin
               ph_in = neg_ff ? PH_SEVEN - dq_ff[PH_W-1:0] : PH_SEVEN + dq_ff[PH_W-1:0];
            end
            state_in = S_SMTH;
         end

         // Choose the fast or slow smoothing factor from the step size.
         S_SMTH: begin
            neg_in   = dsm[PH_W];
            dq_in    = DQ_W'(sm_load);
            rem_in   = '0;
            dsor_in  = dbig ? DSOR_W'(SMOOTH_FAST_DIV) : DSOR_W'(SMOOTH_SLOW_DIV);
            step_in  = STEP_W'(DQ_W - 1);
            state_in = S_DIVS;
         end

         // Publish once the output register is free.
         S_OUT: begin
            if (out_free) begin
               if (first_ff) begin
                  smooth_in = ph_ff;
               end else begin
                  smooth_in = neg_ff ? smooth_ff - sq : smooth_ff + sq;
               end
               first_in     = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_filt_in  = filt_ff;
               rsp_probe_in = filt_ff[VOLT_W-1] ? -$signed(phalf) : $signed(phalf);
               rsp_phi_in   = ph_ff;
               rsp_phs_in   = smooth_in;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_THEORY;
         cvalid_ff    <= 1'b0;
         neutral_ff   <= '0;
         single_ff    <= SLOPE_RESET;
         acid_ff      <= SLOPE_RESET;
         base_ff      <= SLOPE_RESET;
         toff_ff      <= '0;
         tslope_ff    <= SLOPE_RESET;
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         hptr_ff      <= '0;
         hfill_ff     <= '0;
         first_ff     <= 1'b1;
         smooth_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         cvalid_ff    <= cvalid_in;
         neutral_ff   <= neutral_in;
         single_ff    <= single_in;
         acid_ff      <= acid_in;
         base_ff      <= base_in;
         toff_ff      <= toff_in;
         tslope_ff    <= tslope_in;
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         hptr_ff      <= hptr_in;
         hfill_ff     <= hfill_in;
         first_ff     <= first_in;
         smooth_ff    <= smooth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         hist_ff[i] <= hist_in[i];
      end
      dq_ff        <= dq_in;
      rem_ff       <= rem_in;
      dsor_ff      <= dsor_in;
      step_ff      <= step_in;
      neg_ff       <= neg_in;
      filt_ff      <= filt_in;
      mcand_ff     <= mcand_in;
      prod_ff      <= prod_in;
      ph_ff        <= ph_in;
      rsp_filt_ff  <= rsp_filt_in;
      rsp_probe_ff <= rsp_probe_in;
      rsp_phi_ff   <= rsp_phi_in;
      rsp_phs_ff   <= rsp_phs_in;
   end

`include "ph_sample_filter_and_calibration_assert.svh"

   // Both published pH values stay inside 0..14 pH.
   `PSFC_ASSERT_IMP(a_ph_range, clock, reset, rsp_valid_ff, rsp_phi_ff <= PH_MAX && rsp_phs_ff <= PH_MAX)

   // Until the median window is full, the write pointer tracks the fill count.
   `PSFC_ASSERT_IMP(a_hist_fill, clock, reset, hfill_ff != 2'd3, hptr_ff == hfill_ff)

   // The request that closes a block starts the average division and clears the count.
   `PSFC_ASSERT_NXT(a_block_end, clock, reset, req_take && block_end, state_ff == S_DIVV && count_ff == '0)

endmodule
